FILE: rtl/hvtd_pkg.sv
package hvtd_pkg;

  localparam int NUM_TAGS_DEF   = 32;
  localparam int MAX_WORDS_DEF  = 64;
  localparam int SCORE_BITS_DEF = 16;

  localparam int TAG_W  = 5;
  localparam int IDX_W  = 6;
  localparam int LOG_W  = 16;
  localparam int FROM_W = 6;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_EMIT  = 2'd1,
    KIND_WORD  = 2'd2,
    KIND_SENT  = 2'd3
  } kind_t;

  localparam logic [1:0] ST_TAG   = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FROM_W-1:0] from_tag;
    logic [TAG_W-1:0]  to_tag;
    logic signed [LOG_W-1:0] log_value;
  } cmd_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [IDX_W-1:0] word_index;
    logic             last;
    logic [1:0]       status;
  } res_t;

endpackage

FILE: rtl/hvtd_acs.sv
module hvtd_acs import hvtd_pkg::*; #(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic signed [SCORE_BITS+7:0] path,
  input  logic signed [SCORE_BITS-1:0] score,
  output logic signed [SCORE_BITS+7:0] sum
);
  localparam int PW = SCORE_BITS + 8;
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

  logic signed [PW:0] wide;

  always_comb begin
    wide = {path[PW-1], path} + (PW+1)'(score);
    if (path == PMIN || score == SMIN) begin
      sum = PMIN;
    end else if (wide > $signed({PMAX[PW-1], PMAX})) begin
      sum = PMAX;
    end else if (wide < $signed({PMIN[PW-1], PMIN})) begin
      sum = PMIN;
    end else begin
      sum = wide[PW-1:0];
    end
  end
endmodule

FILE: rtl/hmm_viterbi_tag_decoder.sv
// hmm_viterbi_tag_decoder
// Command channel: cmd is taken at a clock edge with start high and busy low.
// kind 0 writes one transition entry, kind 1 one emission score; both
// leave busy low and produce nothing.
// kind 2 closes a word: one shared add-compare-select unit walks all
// NUM_TAGS x NUM_TAGS source/destination pairs, each tag's sources then one
// emission add for that tag, then a read-then-write copy of the work bank
// per tag. The first word adds only the row-0 transition and emission per tag.
// kind 3 closes the sentence: a scan for the best final tag, a backtrace
// of one back-pointer read per word after the first and then one result
// per word on res, each from a stored-tag read, marked by res_valid, in word
// order with last set on the final one. Afterwards a clear of the path and
// emission scores runs while busy stays high.
// Results cannot be held off: each is on res for exactly one cycle.
// A word beyond MAX_WORDS gives one result with status 1; an empty
// sentence gives one with status 2.
// Reset (rst, synchronous) clears all 2*NUM_TAGS path entries and the
// emission scores with busy high. The transition table is kept undefined
// until written.
module hmm_viterbi_tag_decoder import hvtd_pkg::*; #(
  parameter int NUM_TAGS   = NUM_TAGS_DEF,
  parameter int MAX_WORDS  = MAX_WORDS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic res_valid,
  output res_t res
);
  localparam int TW  = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
  localparam int WW  = $clog2(MAX_WORDS);
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int PW  = SCORE_BITS + 8;
  localparam int TRD = (NUM_TAGS + 1) * NUM_TAGS;
  localparam int TRW = $clog2(TRD);
  localparam int BPD = MAX_WORDS * NUM_TAGS;
  localparam int BPW = $clog2(BPD);
  localparam int PSW = $clog2(2 * NUM_TAGS);
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
  localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_RD   = 11'b00000000100,
    S_ACS  = 11'b00000001000,
    S_EMI  = 11'b00000010000,
    S_COPY = 11'b00000100000,
    S_BEST = 11'b00001000000,
    S_BT   = 11'b00010000000,
    S_BTW  = 11'b00100000000,
    S_OUT  = 11'b01000000000,
    S_ECLR = 11'b10000000000
  } state_t;

  logic signed [SCORE_BITS-1:0] trans [TRD];
  logic signed [PW-1:0]         paths [2*NUM_TAGS];
  logic [TW-1:0]                bptr  [BPD];
  logic [TW-1:0]                tags  [MAX_WORDS];
  logic signed [SCORE_BITS-1:0] emis  [NUM_TAGS];

  state_t state;
  logic [CW-1:0] word_count;
  logic [TW-1:0] t, p;
  logic [PSW:0]  ci;
  logic [CW-1:0] w;
  logic signed [PW-1:0] best;
  logic [TW-1:0] best_p;
  logic signed [SCORE_BITS-1:0] tr_q;
  logic signed [PW-1:0] ps_q;
  logic [TW-1:0] bp_q;
  logic [TW-1:0] tag_q;
  logic [TW-1:0] cur;
  logic signed [SCORE_BITS-1:0] cval;
  logic signed [PW-1:0] acs_sum;
  logic signed [PW-1:0] acs_path;
  logic signed [SCORE_BITS-1:0] acs_score;
  logic first;

  always_comb begin
    if (cmd.log_value < $signed(LOG_W'(SMIN)) && SCORE_BITS < LOG_W) begin
      cval = SMIN;
    end else if (cmd.log_value > $signed(LOG_W'(SMAX)) && SCORE_BITS < LOG_W) begin
      cval = SMAX;
    end else begin
      cval = SCORE_BITS'(cmd.log_value);
    end
  end

  // shared unit: ACS phase adds transition; emission phase adds emission
  always_comb begin
    if (state == S_EMI) begin
      acs_path  = best;
      acs_score = emis[t];
    end else begin
      acs_path  = first ? '0 : ps_q;
      acs_score = tr_q;
    end
  end

  hvtd_acs #(.SCORE_BITS(SCORE_BITS)) u_acs (
    .path(acs_path), .score(acs_score), .sum(acs_sum)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (start && !busy && cmd.kind == KIND_LOAD &&
        32'(cmd.from_tag) <= NUM_TAGS && 32'(cmd.to_tag) < NUM_TAGS) begin
      trans[TRW'(32'(cmd.from_tag) * NUM_TAGS + 32'(cmd.to_tag))] <= cval;
    end
    tr_q <= trans[TRW'(first ? 32'(t) : (32'(p) + 1) * NUM_TAGS + 32'(t))];
    ps_q <= paths[PSW'(state == S_COPY ? NUM_TAGS + 32'(p) : 32'(p))];
    bp_q <= bptr[BPW'(32'(w[WW-1:0]) * NUM_TAGS + 32'(cur))];
    tag_q <= tags[w[WW-1:0]];
    if (state == S_EMI && !first) begin
      bptr[BPW'(32'(word_count[WW-1:0]) * NUM_TAGS + 32'(t))] <= best_p;
    end
    if (state == S_BT) begin
      tags[w[WW-1:0]] <= cur;
    end
  end

  // path bank write port: clear, ACS result, or copy
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      paths[ci[PSW-1:0]] <= PMIN;
    end else if (state == S_EMI) begin
      paths[PSW'(first ? 32'(t) : NUM_TAGS + 32'(t))] <= acs_sum;
    end else if (state == S_COPY && ci[0]) begin
      paths[PSW'(32'(p))] <= ps_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state == S_CLR || state == S_ECLR) begin
      for (int i = 0; i < NUM_TAGS; i++) emis[i] <= SMIN;
    end else if (start && !busy && cmd.kind == KIND_EMIT &&
                 32'(cmd.to_tag) < NUM_TAGS) begin
      emis[cmd.to_tag[TW-1:0]] <= cval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      ci         <= '0;
      word_count <= '0;
      res_valid  <= 1'b0;
      t <= '0; p <= '0; w <= '0; first <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_CLR: begin
          ci <= ci + 1'b1;
          if (32'(ci) == 2 * NUM_TAGS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            case (kind_t'(cmd.kind))
              KIND_WORD: begin
                if (32'(word_count) >= MAX_WORDS) begin
                  res_valid      <= 1'b1;
                  res.tag        <= '0;
                  res.word_index <= IDX_W'(word_count);
                  res.last       <= 1'b1;
                  res.status     <= ST_LIMIT;
                  state          <= S_ECLR;
                end else begin
                  first <= (word_count == '0);
                  t <= '0; p <= '0;
                  best <= PMIN; best_p <= '0;
                  state <= S_RD;
                end
              end
              KIND_SENT: begin
                if (word_count == '0) begin
                  res_valid      <= 1'b1;
                  res.tag        <= '0;
                  res.word_index <= '0;
                  res.last       <= 1'b1;
                  res.status     <= ST_EMPTY;
                  state          <= S_IDLE;
                end else begin
                  p <= '0; best <= PMIN; cur <= '0;
                  state <= S_BEST;
                  ci <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state <= S_ACS;
        S_ACS: begin
          if (acs_sum >= best) begin
            best   <= acs_sum;
            best_p <= p;
          end
          if (first || 32'(p) == NUM_TAGS - 1) begin
            state <= S_EMI;
          end else begin
            p <= p + 1'b1;
            state <= S_RD;
          end
        end
        S_EMI: begin
          best <= PMIN; best_p <= '0; p <= '0;
          if (32'(t) == NUM_TAGS - 1) begin
            if (first) begin
              word_count <= word_count + 1'b1;
              state <= S_ECLR;
            end else begin
              ci <= '0; p <= '0;
              state <= S_COPY;
            end
          end else begin
            t <= t + 1'b1;
            state <= S_RD;
          end
        end
        S_COPY: begin
          // even phase reads upper bank entry into ps_q, odd phase writes
          ci <= ci + 1'b1;
          if (!ci[0]) begin
            p <= p;
          end else if (32'(p) == NUM_TAGS - 1) begin
            word_count <= word_count + 1'b1;
            state <= S_ECLR;
          end else begin
            p <= p + 1'b1;
          end
        end
        S_BEST: begin
          ci <= ci + 1'b1;
          if (ci[0]) begin
            if (ps_q >= best) begin
              best <= ps_q;
              cur  <= p;
            end
            if (32'(p) == NUM_TAGS - 1) begin
              w <= word_count - 1'b1;
              state <= S_BT;
            end else begin
              p <= p + 1'b1;
            end
          end
        end
        S_BT: begin
          if (w == '0) begin
            ci <= '0;
            state <= S_OUT;
          end else begin
            state <= S_BTW;
          end
        end
        S_BTW: begin
          cur <= bp_q;
          w <= w - 1'b1;
          state <= S_BT;
        end
        S_OUT: begin
          // even phase reads the stored tag, odd phase issues the result
          ci <= ci + 1'b1;
          if (ci[0]) begin
            res_valid      <= 1'b1;
            res.tag        <= TAG_W'(tag_q);
            res.word_index <= IDX_W'(w);
            res.last       <= (w + 1'b1 == word_count);
            res.status     <= ST_TAG;
            if (w + 1'b1 == word_count) begin
              word_count <= '0;
              ci <= '0;
              state <= S_CLR;
            end else begin
              w <= w + 1'b1;
            end
          end
        end
        S_ECLR: state <= S_IDLE;
        default: state <= S_CLR;
      endcase
    end
  end
endmodule

FILE: rtl/hvtd_checker.sv
module hvtd_checker import hvtd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input cmd_t cmd,
  input logic busy,
  input logic res_valid,
  input res_t res
);
  a_no_res_idle_load: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.kind == KIND_LOAD |=> !res_valid)
    else $error("result after load");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_TAG |-> res.last)
    else $error("error result not last");
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("idle right after reset");
  a_res_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.status != 2'd3)
    else $error("bad status");
endmodule

bind hmm_viterbi_tag_decoder hvtd_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .cmd(cmd),
  .busy(busy), .res_valid(res_valid), .res(res)
);

FILE: dv/hmm_viterbi_tag_decoder_test.sv
`timescale 1ns / 1ps

module hmm_viterbi_tag_decoder_test;
  import hvtd_pkg::*;

  localparam int NT = NUM_TAGS_DEF;
  localparam int MW = MAX_WORDS_DEF;
  localparam longint SC_MIN = -(64'sd1 <<< (SCORE_BITS_DEF - 1));
  localparam longint PA_MIN = -(64'sd1 <<< (SCORE_BITS_DEF + 7));
  localparam longint PA_MAX = (64'sd1 <<< (SCORE_BITS_DEF + 7)) - 1;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic res_valid;
  res_t res;

  longint trans_sc[(NT + 1) * NT];
  longint emit_sc[NT];
  longint path_sc[NT];
  logic [4:0] back_ptr[MW][NT];
  int word_cnt;

  res_t tags_due[$];
  int errors = 0;
  int n_sent = 0;

  hmm_viterbi_tag_decoder i_dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint add_sc(longint p, longint s);
    longint v;
    if (p <= PA_MIN || s <= SC_MIN) return PA_MIN;
    v = p + s;
    if (v < PA_MIN) v = PA_MIN;
    if (v > PA_MAX) v = PA_MAX;
    return v;
  endfunction

  function automatic void clear_emis();
    foreach (emit_sc[t]) emit_sc[t] = SC_MIN;
  endfunction

  function automatic void viterbi_step(cmd_t c, ref res_t out[$]);
    longint v, best;
    longint nxt[NT];
    int bp, cur;
    logic [4:0] path_tags[MW];
    res_t r;
    out.delete();
    v = longint'(c.log_value);
    case (c.kind)
      KIND_LOAD: if (c.from_tag <= NT) trans_sc[c.from_tag * NT + c.to_tag] = v;
      KIND_EMIT: emit_sc[c.to_tag] = v;
      KIND_WORD: begin
        if (word_cnt >= MW) begin
          clear_emis();
          r = '{tag: '0, word_index: word_cnt[5:0], last: 1'b1, status: ST_LIMIT};
          out = {out, r};
        end else begin
          if (word_cnt == 0) begin
            for (int t = 0; t < NT; t++)
              path_sc[t] = add_sc(add_sc(0, trans_sc[t]), emit_sc[t]);
          end else begin
            for (int t = 0; t < NT; t++) begin
              best = PA_MIN;
              bp = 0;
              for (int p = 0; p < NT; p++) begin
                v = add_sc(path_sc[p], trans_sc[(p + 1) * NT + t]);
                if (v >= best) begin
                  best = v;
                  bp = p;
                end
              end
              back_ptr[word_cnt][t] = bp[4:0];
              nxt[t] = add_sc(best, emit_sc[t]);
            end
            path_sc = nxt;
          end
          word_cnt++;
          clear_emis();
        end
      end
      default: begin
        if (word_cnt == 0) begin
          r = '{tag: '0, word_index: '0, last: 1'b1, status: ST_EMPTY};
          out = {out, r};
        end else begin
          best = PA_MIN;
          cur = 0;
          for (int t = 0; t < NT; t++)
            if (path_sc[t] >= best) begin
              best = path_sc[t];
              cur = t;
            end
          for (int w = word_cnt - 1; w >= 0; w--) begin
            path_tags[w] = cur[4:0];
            if (w > 0) cur = back_ptr[w][cur];
          end
          for (int w = 0; w < word_cnt; w++) begin
            r = '{tag: path_tags[w], word_index: w[5:0], last: (w + 1 == word_cnt),
                  status: ST_TAG};
            out = {out, r};
          end
          word_cnt = 0;
          foreach (path_sc[t]) path_sc[t] = PA_MIN;
          clear_emis();
        end
      end
    endcase
  endfunction

  // one command transfer; typed rows replace the predicted results
  task automatic issue(cmd_t c, bit typed = 1'b0, res_t typed_r = '0);
    res_t got[$];
    if (!(n_sent >= 100 && n_sent < 160) && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    viterbi_step(c, got);
    if (typed) tags_due = {tags_due, typed_r};
    else foreach (got[i]) tags_due = {tags_due, got[i]};
    n_sent++;
  endtask

  function automatic cmd_t mk(kind_t k, int f, int t, int v);
    cmd_t c;
    c.kind = k;
    c.from_tag = f[5:0];
    c.to_tag = t[4:0];
    c.log_value = v[15:0];
    return c;
  endfunction

  function automatic int rnd_log();
    int s;
    s = $urandom_range(9);
    if (s == 0) return -32768;
    if (s == 1) return 0;
    if (s < 5) return -int'($urandom_range(32768));
    return -int'($urandom_range(3000));
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid) begin
      if (tags_due.size() == 0) begin
        $error("unexpected result tag=%0d word_index=%0d", res.tag, res.word_index);
        errors++;
      end else begin
        e = tags_due.pop_front();
        if (res.tag !== e.tag) begin
          $error("tag: expected %0d, got %0d", e.tag, res.tag);
          errors++;
        end
        if (res.word_index !== e.word_index) begin
          $error("word_index: expected %0d, got %0d", e.word_index, res.word_index);
          errors++;
        end
        if (res.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, res.last);
          errors++;
        end
        if (res.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, res.status);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t rows[$];
    res_t r;
    int nw;
    rows = '{
      '{mk(KIND_SENT, 0, 0, 0), 1'b1, '{5'd0, 6'd0, 1'b1, ST_EMPTY}},
      '{mk(KIND_EMIT, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 31, -32768), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 5, -1), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 21, -21846), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 10, 0), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_SENT, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_LOAD, 32, 31, 0), 1'b0, '0},
      '{mk(KIND_LOAD, 0, 0, -32768), 1'b0, '0},
      '{mk(KIND_LOAD, 0, 31, 0), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 31, -256), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_EMIT, 0, 31, 0), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_SENT, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_WORD, 0, 0, 0), 1'b0, '0},
      '{mk(KIND_SENT, 0, 0, 0), 1'b0, '0}
    };
    start <= 1'b0;
    cmd <= '0;
    rst <= 1'b1;
    word_cnt = 0;
    clear_emis();
    foreach (path_sc[t]) path_sc[t] = PA_MIN;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // whole table first: no close word may read an unwritten entry
    issue(rows[0].c, rows[0].typed, rows[0].r);
    for (int f = 0; f <= NT; f++)
      for (int t = 0; t < NT; t++) issue(mk(KIND_LOAD, f, t, rnd_log()));
    for (int i = 1; i < rows.size(); i++) issue(rows[i].c, rows[i].typed, rows[i].r);

    // word limit
    for (int w = 0; w < MW; w++) begin
      issue(mk(KIND_EMIT, 0, $urandom_range(31), rnd_log()));
      issue(mk(KIND_WORD, 0, 0, 0));
    end
    issue(mk(KIND_EMIT, 0, 3, 0));
    r = '{tag: '0, word_index: 6'd0, last: 1'b1, status: ST_LIMIT};
    issue(mk(KIND_WORD, 0, 0, 0), 1'b1, r);
    issue(mk(KIND_SENT, 0, 0, 0));

    n_sent = 0;
    while (n_sent < 250) begin
      if ($urandom_range(19) == 0) begin
        issue(mk(KIND_SENT, 0, 0, 0));
      end else begin
        nw = $urandom_range(1, 6);
        for (int w = 0; w < nw; w++) begin
          if ($urandom_range(9) == 0)
            issue(mk(KIND_LOAD, $urandom_range(NT), $urandom_range(31), rnd_log()));
          repeat ($urandom_range(8)) issue(mk(KIND_EMIT, 0, $urandom_range(31), rnd_log()));
          issue(mk(KIND_WORD, 0, 0, 0));
        end
        issue(mk(KIND_SENT, 0, 0, 0));
      end
    end
    start <= 1'b0;

    while (tags_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && tags_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/hvtd_pkg.sv
rtl/hvtd_acs.sv
rtl/hmm_viterbi_tag_decoder.sv
rtl/hvtd_checker.sv
dv/hmm_viterbi_tag_decoder_test.sv
